// ----- src/hgc_pkg.sv -----
// Shared types and constants of the hue gauge color core.
// Used by the channel interfaces and by every module in the core; depends on nothing.
package hgc_pkg;

	// Field widths.
	localparam int VAL_W = 16;
	localparam int HUE_W = 11;
	localparam int CH_W  = 8;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_PROFILE_SELECT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VALUE_LOW      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VALUE_MEDIUM   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_VALUE_HIGH     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HUE_LOW        = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HUE_MEDIUM     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_HUE_HIGH       = 3'd6;

	// Reset values, which are also the built-in profile.
	localparam logic [VAL_W-1:0] VALUE_LOW_DEF    = 16'd400;
	localparam logic [VAL_W-1:0] VALUE_MEDIUM_DEF = 16'd800;
	localparam logic [VAL_W-1:0] VALUE_HIGH_DEF   = 16'd1000;
	localparam logic [HUE_W-1:0] HUE_LOW_DEF      = 11'd510;
	localparam logic [HUE_W-1:0] HUE_MEDIUM_DEF   = 11'd1020;
	localparam logic [HUE_W-1:0] HUE_HIGH_DEF     = 11'd1530;

	// Hue wheel.
	localparam logic [HUE_W-1:0] HUE_STEPS = 11'd1530;
	localparam logic [HUE_W-1:0] WHEEL_B1  = 11'd255;
	localparam logic [HUE_W-1:0] WHEEL_B2  = 11'd510;
	localparam logic [HUE_W-1:0] WHEEL_B3  = 11'd765;
	localparam logic [HUE_W-1:0] WHEEL_B4  = 11'd1020;
	localparam logic [HUE_W-1:0] WHEEL_B5  = 11'd1275;
	localparam logic [CH_W-1:0]  CH_FULL   = 8'd255;

	// Division: the quotient carries a bias of 2^(QUO_W-1) so that the
	// dividend is never negative.
	localparam int QUO_W        = 12;
	localparam int NUM_W        = 30;
	localparam int DEN2_W       = VAL_W + 1;
	localparam int REM_W        = DEN2_W;
	localparam int DIV_STEPS    = 3;
	localparam int DIV_STAGES   = QUO_W / DIV_STEPS;
	localparam int SUM_W        = QUO_W + 1;
	localparam logic [SUM_W-1:0] QUO_BIAS = 13'd2048;

	// Register file as seen by the datapath.
	typedef struct packed {
		logic             profile_select;
		logic [VAL_W-1:0] value_low;
		logic [VAL_W-1:0] value_medium;
		logic [VAL_W-1:0] value_high;
		logic [HUE_W-1:0] hue_low;
		logic [HUE_W-1:0] hue_medium;
		logic [HUE_W-1:0] hue_high;
	} cfg_t;

	// Item after segment selection: a clamp value or a division to do.
	typedef struct packed {
		logic              interp;
		logic [HUE_W-1:0]  base;
		logic [NUM_W-1:0]  num;
		logic [DEN2_W-1:0] den2;
	} frac_t;

	// Item after division.
	typedef struct packed {
		logic             interp;
		logic [HUE_W-1:0] base;
		logic [QUO_W-1:0] quo;
	} quo_t;

endpackage

// ----- src/hgc_ifs.sv -----
// Valid/ready channel interfaces for readings and colors.
// Depends on hgc_pkg for the field widths.
interface hgc_in_if;
	logic                      valid;
	logic                      ready;
	logic [hgc_pkg::VAL_W-1:0] reading;

	modport source (output valid, output reading, input ready);
	modport sink (input valid, input reading, output ready);
endinterface

interface hgc_out_if;
	logic                      valid;
	logic                      ready;
	logic [hgc_pkg::HUE_W-1:0] hue_index;
	logic [hgc_pkg::CH_W-1:0]  red;
	logic [hgc_pkg::CH_W-1:0]  green;
	logic [hgc_pkg::CH_W-1:0]  blue;

	modport source (output valid, output hue_index, output red, output green, output blue,
		input ready);
	modport sink (input valid, input hue_index, input red, input green, input blue,
		output ready);
endinterface

// ----- src/hgc_seg.sv -----
// Segment selection, slope multiply and dividend forming: three pipeline stages.
// Depends on hgc_pkg.
module hgc_seg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  hgc_pkg::cfg_t                 cfg,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [hgc_pkg::VAL_W-1:0]     in_reading,
	output logic                          out_valid,
	input  logic                          out_ready,
	output hgc_pkg::frac_t                out_frac
);

	// Stage handshake.
	logic vld_s1, vld_s2, vld_s3;
	logic en_s1, en_s2, en_s3;

	assign en_s3    = !vld_s3 || out_ready;
	assign en_s2    = !vld_s2 || en_s3;
	assign en_s1    = !vld_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= in_valid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_s2;
		end
	end

	// Stage 1: pick the breakpoint set and the segment that the reading falls in.
	logic [hgc_pkg::VAL_W-1:0] vl, vm, vh, v0, den, t;
	logic [hgc_pkg::HUE_W-1:0] cl, cm, ch, base, c1;
	logic                      interp;
	logic signed [hgc_pkg::HUE_W:0] dc;

	always_comb begin
		if (cfg.profile_select) begin
			vl = hgc_pkg::VALUE_LOW_DEF;
			vm = hgc_pkg::VALUE_MEDIUM_DEF;
			vh = hgc_pkg::VALUE_HIGH_DEF;
			cl = hgc_pkg::HUE_LOW_DEF;
			cm = hgc_pkg::HUE_MEDIUM_DEF;
			ch = hgc_pkg::HUE_HIGH_DEF;
		end else begin
			vl = cfg.value_low;
			vm = cfg.value_medium;
			vh = cfg.value_high;
			cl = cfg.hue_low;
			cm = cfg.hue_medium;
			ch = cfg.hue_high;
		end
		if (in_reading <= vl) begin
			interp = 1'b0;
			base   = cl;
			v0     = vl;
			den    = vm - vl;
			c1     = cm;
		end else if (in_reading <= vm) begin
			interp = 1'b1;
			base   = cl;
			v0     = vl;
			den    = vm - vl;
			c1     = cm;
		end else if (in_reading <= vh) begin
			interp = 1'b1;
			base   = cm;
			v0     = vm;
			den    = vh - vm;
			c1     = ch;
		end else begin
			interp = 1'b0;
			base   = ch;
			v0     = vm;
			den    = vh - vm;
			c1     = ch;
		end
		t  = in_reading - v0;
		dc = signed'({1'b0, c1}) - signed'({1'b0, base});
	end

	logic                           interp_s1;
	logic [hgc_pkg::HUE_W-1:0]      base_s1;
	logic [hgc_pkg::VAL_W-1:0]      t_s1, den_s1;
	logic signed [hgc_pkg::HUE_W:0] dc_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			interp_s1 <= interp;
			base_s1   <= base;
			t_s1      <= t;
			den_s1    <= den;
			dc_s1     <= dc;
		end
	end

	// Stage 2: offset into the segment times the hue difference.
	logic signed [hgc_pkg::VAL_W:0] t_sx;
	logic signed [28:0]             prod_full;
	logic                           interp_s2;
	logic [hgc_pkg::HUE_W-1:0]      base_s2;
	logic [hgc_pkg::VAL_W-1:0]      den_s2;
	logic signed [27:0]             prod_s2;

	assign t_sx      = signed'({1'b0, t_s1});
	assign prod_full = 29'(t_sx) * 29'(dc_s1);

	always_ff @(posedge clk) begin
		if (en_s2) begin
			interp_s2 <= interp_s1;
			base_s2   <= base_s1;
			den_s2    <= den_s1;
			prod_s2   <= signed'(prod_full[27:0]);
		end
	end

	// Stage 3: dividend 2*prod + den plus the bias 2^11 * 2*den, and divisor 2*den.
	logic signed [30:0] num_full;

	assign num_full = (31'(prod_s2) <<< 1)
		+ signed'({3'b0, den_s2, 12'b0})
		+ signed'({15'b0, den_s2});

	always_ff @(posedge clk) begin
		if (en_s3) begin
			out_frac.interp <= interp_s2;
			out_frac.base   <= base_s2;
			out_frac.num    <= num_full[hgc_pkg::NUM_W-1:0];
			out_frac.den2   <= {den_s2, 1'b0};
		end
	end

	assign out_valid = vld_s3;

endmodule

// ----- src/hgc_div.sv -----
// Pipelined restoring divider: a few quotient bits per stage.
// Depends on hgc_pkg.
module hgc_div (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  hgc_pkg::frac_t in_frac,
	output logic           out_valid,
	input  logic           out_ready,
	output hgc_pkg::quo_t  out_quo
);

	typedef struct packed {
		logic                       interp;
		logic [hgc_pkg::HUE_W-1:0]  base;
		logic [hgc_pkg::DEN2_W-1:0] den2;
		logic [hgc_pkg::REM_W-1:0]  rem;
		logic [hgc_pkg::QUO_W-1:0]  num_lo;
		logic [hgc_pkg::QUO_W-1:0]  quo;
	} div_st_t;

	// One restoring step: bring down a dividend bit, subtract when it fits.
	function automatic div_st_t div_step(input div_st_t st);
		div_st_t                  nx;
		logic [hgc_pkg::REM_W:0]  rs;
		logic [hgc_pkg::REM_W:0]  diff;
		logic                     fit;
		nx   = st;
		rs   = {st.rem, st.num_lo[hgc_pkg::QUO_W-1]};
		diff = rs - {1'b0, st.den2};
		fit  = (rs >= {1'b0, st.den2});
		nx.rem    = fit ? diff[hgc_pkg::REM_W-1:0] : rs[hgc_pkg::REM_W-1:0];
		nx.num_lo = {st.num_lo[hgc_pkg::QUO_W-2:0], 1'b0};
		nx.quo    = {st.quo[hgc_pkg::QUO_W-2:0], fit};
		return nx;
	endfunction

	// The partial remainder starts as the dividend's upper bits, known to be below the divisor.
	div_st_t first;

	always_comb begin
		first.interp = in_frac.interp;
		first.base   = in_frac.base;
		first.den2   = in_frac.den2;
		first.rem    = in_frac.num[hgc_pkg::QUO_W +: hgc_pkg::REM_W];
		first.num_lo = in_frac.num[hgc_pkg::QUO_W-1:0];
		first.quo    = '0;
	end

	div_st_t                      div_s [hgc_pkg::DIV_STAGES];
	logic [hgc_pkg::DIV_STAGES-1:0] vld_s;
	logic [hgc_pkg::DIV_STAGES-1:0] en_s;

	assign in_ready = en_s[0];

	for (genvar k = 0; k < hgc_pkg::DIV_STAGES; k++) begin : g_stage
		div_st_t prev;
		div_st_t nxt;
		logic    prev_vld;
		logic    nxt_rdy;

		if (k == 0) begin : g_head
			assign prev     = first;
			assign prev_vld = in_valid;
		end else begin : g_body
			assign prev     = div_s[k-1];
			assign prev_vld = vld_s[k-1];
		end

		if (k == hgc_pkg::DIV_STAGES - 1) begin : g_tail
			assign nxt_rdy = out_ready;
		end else begin : g_mid
			assign nxt_rdy = en_s[k+1];
		end

		assign en_s[k] = !vld_s[k] || nxt_rdy;

		// Steps of this stage, chained.
		always_comb begin
			nxt = prev;
			for (int j = 0; j < hgc_pkg::DIV_STEPS; j++) begin
				nxt = div_step(nxt);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en_s[k]) begin
				vld_s[k] <= prev_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en_s[k]) begin
				div_s[k] <= nxt;
			end
		end
	end

	assign out_valid      = vld_s[hgc_pkg::DIV_STAGES-1];
	assign out_quo.interp = div_s[hgc_pkg::DIV_STAGES-1].interp;
	assign out_quo.base   = div_s[hgc_pkg::DIV_STAGES-1].base;
	assign out_quo.quo    = div_s[hgc_pkg::DIV_STAGES-1].quo;

endmodule

// ----- src/hgc_wheel.sv -----
// Hue index forming, reduction modulo the wheel size and the hue wheel lookup.
// Depends on hgc_pkg and the output channel interface.
module hgc_wheel (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  hgc_pkg::quo_t in_quo,
	hgc_out_if.source     rsp
);

	logic vld_s1, vld_s2, en_s1, en_s2;

	assign en_s2    = !vld_s2 || rsp.ready;
	assign en_s1    = !vld_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= in_valid;
			if (en_s2) vld_s2 <= vld_s1;
		end
	end

	// Stage 1: remove the quotient bias, add the segment base, reduce once.
	logic [hgc_pkg::SUM_W-1:0] sum;
	logic [hgc_pkg::HUE_W-1:0] c, c_mod;
	logic [hgc_pkg::HUE_W-1:0] hue_s1;

	always_comb begin
		sum = {2'b0, in_quo.base}
			+ (in_quo.interp ? {1'b0, in_quo.quo} : hgc_pkg::QUO_BIAS)
			- hgc_pkg::QUO_BIAS;
		c     = sum[hgc_pkg::HUE_W-1:0];
		c_mod = (c >= hgc_pkg::HUE_STEPS) ? c - hgc_pkg::HUE_STEPS : c;
	end

	always_ff @(posedge clk) begin
		if (en_s1) hue_s1 <= c_mod;
	end

	// Stage 2: six-segment wheel into the output register.
	logic [hgc_pkg::CH_W-1:0]  r, g, b;
	logic [hgc_pkg::HUE_W-1:0] d;

	always_comb begin
		r = '0;
		g = '0;
		b = '0;
		d = '0;
		if (hue_s1 < hgc_pkg::WHEEL_B1) begin
			r = hgc_pkg::CH_FULL;
			b = hue_s1[hgc_pkg::CH_W-1:0];
		end else if (hue_s1 < hgc_pkg::WHEEL_B2) begin
			d = hgc_pkg::WHEEL_B2 - hue_s1;
			r = d[hgc_pkg::CH_W-1:0];
			b = hgc_pkg::CH_FULL;
		end else if (hue_s1 < hgc_pkg::WHEEL_B3) begin
			d = hue_s1 - hgc_pkg::WHEEL_B2;
			g = d[hgc_pkg::CH_W-1:0];
			b = hgc_pkg::CH_FULL;
		end else if (hue_s1 < hgc_pkg::WHEEL_B4) begin
			d = hgc_pkg::WHEEL_B4 - hue_s1;
			g = hgc_pkg::CH_FULL;
			b = d[hgc_pkg::CH_W-1:0];
		end else if (hue_s1 < hgc_pkg::WHEEL_B5) begin
			d = hue_s1 - hgc_pkg::WHEEL_B4;
			r = d[hgc_pkg::CH_W-1:0];
			g = hgc_pkg::CH_FULL;
		end else begin
			d = hgc_pkg::HUE_STEPS - hue_s1;
			r = hgc_pkg::CH_FULL;
			g = d[hgc_pkg::CH_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			rsp.hue_index <= hue_s1;
			rsp.red       <= r;
			rsp.green     <= g;
			rsp.blue      <= b;
		end
	end

	assign rsp.valid = vld_s2;

endmodule

// ----- src/value_to_hue_gauge_color_core.sv -----
// Top level of the hue gauge color core: configuration registers and the pipeline.
// Depends on hgc_pkg, hgc_ifs, hgc_seg, hgc_div and hgc_wheel.
//
// Maps each 16-bit reading to a hue index on a 1530-step wheel and its RGB color.
// Readings at or below value_low get hue_low, readings above value_high get
// hue_high, and readings in between are linearly interpolated along the low or
// high segment, rounded to nearest with halves up, then reduced modulo 1530.
// Setting profile_select uses the built-in 400/800/1000 and 510/1020/1530 set.
// The core takes one item per clock cycle while the output is not stalled. Each
// item passes through the segment stages, which select the segment and form the
// dividend, the pipelined divider, whose stages produce three quotient bits each,
// and the wheel stages, which reduce the index and look up the wheel.
// Stalls back up stage by stage, so empty stages still fill while the output waits.
// Registers are written through cfg_we/cfg_index/cfg_wdata and should only be
// changed while no item is in flight; writes to indexes above 6 are ignored.
module value_to_hue_gauge_color_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [hgc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [hgc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	hgc_in_if.sink                            req,
	hgc_out_if.source                         rsp
);

	// Configuration registers.
	hgc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.profile_select <= 1'b0;
			cfg_q.value_low      <= hgc_pkg::VALUE_LOW_DEF;
			cfg_q.value_medium   <= hgc_pkg::VALUE_MEDIUM_DEF;
			cfg_q.value_high     <= hgc_pkg::VALUE_HIGH_DEF;
			cfg_q.hue_low        <= hgc_pkg::HUE_LOW_DEF;
			cfg_q.hue_medium     <= hgc_pkg::HUE_MEDIUM_DEF;
			cfg_q.hue_high       <= hgc_pkg::HUE_HIGH_DEF;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hgc_pkg::REG_PROFILE_SELECT: cfg_q.profile_select <= cfg_wdata[0];
				hgc_pkg::REG_VALUE_LOW:      cfg_q.value_low      <= cfg_wdata;
				hgc_pkg::REG_VALUE_MEDIUM:   cfg_q.value_medium   <= cfg_wdata;
				hgc_pkg::REG_VALUE_HIGH:     cfg_q.value_high     <= cfg_wdata;
				hgc_pkg::REG_HUE_LOW:        cfg_q.hue_low    <= cfg_wdata[hgc_pkg::HUE_W-1:0];
				hgc_pkg::REG_HUE_MEDIUM:     cfg_q.hue_medium <= cfg_wdata[hgc_pkg::HUE_W-1:0];
				hgc_pkg::REG_HUE_HIGH:       cfg_q.hue_high   <= cfg_wdata[hgc_pkg::HUE_W-1:0];
				default: ;
			endcase
		end
	end

	// Pipeline sections.
	logic           seg_valid, seg_ready, div_valid, div_ready;
	hgc_pkg::frac_t seg_frac;
	hgc_pkg::quo_t  div_quo;

	hgc_seg u_seg (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (req.valid),
		.in_ready   (req.ready),
		.in_reading (req.reading),
		.out_valid  (seg_valid),
		.out_ready  (seg_ready),
		.out_frac   (seg_frac)
	);

	hgc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (seg_valid),
		.in_ready  (seg_ready),
		.in_frac   (seg_frac),
		.out_valid (div_valid),
		.out_ready (div_ready),
		.out_quo   (div_quo)
	);

	hgc_wheel u_wheel (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (div_valid),
		.in_ready (div_ready),
		.in_quo   (div_quo),
		.rsp      (rsp)
	);

endmodule

// ----- test/value_to_hue_gauge_color_core_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of value_to_hue_gauge_color_core: readings in, hue and RGB out.
// Depends on hgc_pkg, the hgc_ifs channel interfaces and the core itself.
module value_to_hue_gauge_color_core_test;
	import hgc_pkg::*;

	// Index past the last register; writes to it must be ignored.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef struct {
		logic [VAL_W-1:0] reading;
		logic [HUE_W-1:0] hue;
		logic [CH_W-1:0]  red;
		logic [CH_W-1:0]  green;
		logic [CH_W-1:0]  blue;
	} color_t;

	// Holds a copy of the registers, predicts the color of each accepted reading and
	// checks returned colors in order.
	class color_scoreboard;
		cfg_t   regs;
		color_t expected_colors[$];
		int     errors;

		function new();
			regs.profile_select = 1'b0;
			regs.value_low      = VALUE_LOW_DEF;
			regs.value_medium   = VALUE_MEDIUM_DEF;
			regs.value_high     = VALUE_HIGH_DEF;
			regs.hue_low        = HUE_LOW_DEF;
			regs.hue_medium     = HUE_MEDIUM_DEF;
			regs.hue_high       = HUE_HIGH_DEF;
			errors = 0;
		endfunction

		task report(string msg);
			if (errors < 100)
				$display("ERROR at %0t: %s", $realtime, msg);
			errors++;
		endtask

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_PROFILE_SELECT: regs.profile_select = data[0];
				REG_VALUE_LOW:      regs.value_low = data;
				REG_VALUE_MEDIUM:   regs.value_medium = data;
				REG_VALUE_HIGH:     regs.value_high = data;
				REG_HUE_LOW:        regs.hue_low = data[HUE_W-1:0];
				REG_HUE_MEDIUM:     regs.hue_medium = data[HUE_W-1:0];
				REG_HUE_HIGH:       regs.hue_high = data[HUE_W-1:0];
				default: ;
			endcase
		endfunction

		// Linear blend between (v0, c0) and (v1, c1), rounded to nearest, halves up.
		function logic [HUE_W-1:0] blend(int v, int v0, int v1, int c0, int c1);
			longint span, twice_num, twice_span, quo;
			span = longint'(v1) - v0;
			if (span <= 0)
				return c0[HUE_W-1:0];
			twice_num = 2 * (longint'(v) - v0) * (longint'(c1) - c0) + span;
			twice_span = 2 * span;
			if (twice_num >= 0)
				quo = twice_num / twice_span;
			else
				quo = -((-twice_num + twice_span - 1) / twice_span);
			return HUE_W'(c0 + quo);
		endfunction

		function color_t color_of(logic [VAL_W-1:0] reading);
			color_t col;
			int v, vl, vm, vh, cl, cm, ch, c;
			v = reading;
			if (regs.profile_select) begin
				vl = VALUE_LOW_DEF; vm = VALUE_MEDIUM_DEF; vh = VALUE_HIGH_DEF;
				cl = HUE_LOW_DEF; cm = HUE_MEDIUM_DEF; ch = HUE_HIGH_DEF;
			end else begin
				vl = regs.value_low; vm = regs.value_medium; vh = regs.value_high;
				cl = regs.hue_low; cm = regs.hue_medium; ch = regs.hue_high;
			end
			// Breakpoints are tested in a fixed order, so unordered sets still resolve.
			if (v <= vl)
				c = cl;
			else if (v <= vm)
				c = blend(v, vl, vm, cl, cm);
			else if (v <= vh)
				c = blend(v, vm, vh, cm, ch);
			else
				c = ch;
			c = c % int'(HUE_STEPS);
			col.reading = reading;
			col.hue = HUE_W'(c);
			// Six-segment hue wheel.
			if (c < int'(WHEEL_B1)) begin
				col.red = CH_FULL; col.green = '0; col.blue = CH_W'(c);
			end else if (c < int'(WHEEL_B2)) begin
				col.red = CH_W'(int'(WHEEL_B2) - c); col.green = '0; col.blue = CH_FULL;
			end else if (c < int'(WHEEL_B3)) begin
				col.red = '0; col.green = CH_W'(c - int'(WHEEL_B2)); col.blue = CH_FULL;
			end else if (c < int'(WHEEL_B4)) begin
				col.red = '0; col.green = CH_FULL; col.blue = CH_W'(int'(WHEEL_B4) - c);
			end else if (c < int'(WHEEL_B5)) begin
				col.red = CH_W'(c - int'(WHEEL_B4)); col.green = CH_FULL; col.blue = '0;
			end else begin
				col.red = CH_FULL; col.green = CH_W'(int'(HUE_STEPS) - c); col.blue = '0;
			end
			return col;
		endfunction

		function void note_reading(logic [VAL_W-1:0] reading);
			expected_colors.push_back(color_of(reading));
		endfunction

		task check_color(logic [HUE_W-1:0] hue, logic [CH_W-1:0] r, logic [CH_W-1:0] g,
			logic [CH_W-1:0] b);
			color_t want;
			if (expected_colors.size() == 0) begin
				report("color returned with no reading outstanding");
				return;
			end
			want = expected_colors.pop_front();
			if (hue !== want.hue)
				report($sformatf("reading %0d: hue_index %0d, expected %0d",
					want.reading, hue, want.hue));
			if (r !== want.red)
				report($sformatf("reading %0d: red %0d, expected %0d", want.reading, r, want.red));
			if (g !== want.green)
				report($sformatf("reading %0d: green %0d, expected %0d",
					want.reading, g, want.green));
			if (b !== want.blue)
				report($sformatf("reading %0d: blue %0d, expected %0d",
					want.reading, b, want.blue));
		endtask

		function int pending();
			return expected_colors.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	hgc_in_if  req_if ();
	hgc_out_if rsp_if ();

	color_scoreboard sb = new();

	int src_idle_pct = 0;
	int snk_stall_pct = 0;
	int hold_req = 0;

	value_to_hue_gauge_color_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req       (req_if),
		.rsp       (rsp_if)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Run limit, far above the slowest correct run.
	initial begin
		#2000000;
		$display("value_to_hue_gauge_color_core_test NOT OK");
		$finish;
	end

	// Receiver: random stalls, plus long hold-offs requested by the main sequence.
	initial begin
		int hold_left;
		hold_left = 0;
		rsp_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req != 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				rsp_if.ready <= 1'b0;
				hold_left--;
			end else begin
				rsp_if.ready <= ($urandom_range(99) >= snk_stall_pct);
			end
		end
	end

	// Monitor of both channels at the rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_if.valid && req_if.ready)
				sb.note_reading(req_if.reading);
			if (rsp_if.valid && rsp_if.ready)
				sb.check_color(rsp_if.hue_index, rsp_if.red, rsp_if.green, rsp_if.blue);
		end
	end

	// Offers one reading after a random idle gap and returns once it is taken.
	task automatic send_reading(logic [VAL_W-1:0] value);
		while ($urandom_range(99) < src_idle_pct) begin
			req_if.valid <= 1'b0;
			req_if.reading <= VAL_W'($urandom);
			@(negedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.reading <= value;
		do
			@(posedge clk);
		while (!req_if.ready);
		@(negedge clk);
	endtask

	// Stops offering and waits until every expected color has come back.
	task automatic drain(int settle);
		req_if.valid <= 1'b0;
		do
			@(negedge clk);
		while (sb.pending() != 0);
		repeat (settle) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		sb.set_register(idx, data);
		@(negedge clk);
	endtask

	// Writes all seven registers; unused upper data bits carry random noise.
	task automatic program_regs(int ps, int vl, int vm, int vh, int cl, int cm, int ch);
		write_reg(REG_PROFILE_SELECT, {15'($urandom), 1'(ps)});
		write_reg(REG_VALUE_LOW, 16'(vl));
		write_reg(REG_VALUE_MEDIUM, 16'(vm));
		write_reg(REG_VALUE_HIGH, 16'(vh));
		write_reg(REG_HUE_LOW, {5'($urandom), 11'(cl)});
		write_reg(REG_HUE_MEDIUM, {5'($urandom), 11'(cm)});
		write_reg(REG_HUE_HIGH, {5'($urandom), 11'(ch)});
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Picks one of several register sets: built-in profile, ordered, unordered,
	// narrow spans, and extremes with coinciding breakpoints.
	task automatic program_random(int kind);
		int vl, vm, vh, base;
		case (kind)
			0: program_regs(1, $urandom_range(0, 65535), $urandom_range(0, 65535),
				$urandom_range(0, 65535), $urandom_range(0, 2047), $urandom_range(0, 2047),
				$urandom_range(0, 2047));
			1: begin
				vl = $urandom_range(0, 60000);
				vm = $urandom_range(vl + 1, 65000);
				vh = $urandom_range(vm + 1, 65535);
				program_regs(0, vl, vm, vh, $urandom_range(0, 2047), $urandom_range(0, 2047),
					$urandom_range(0, 2047));
			end
			2: program_regs(0, $urandom_range(0, 65535), $urandom_range(0, 65535),
				$urandom_range(0, 65535), $urandom_range(0, 2047), $urandom_range(0, 2047),
				$urandom_range(0, 2047));
			3: begin
				base = $urandom_range(0, 65500);
				vm = base + $urandom_range(1, 7);
				program_regs(0, base, vm, vm + $urandom_range(1, 7), $urandom_range(0, 2047),
					$urandom_range(0, 2047), $urandom_range(0, 2047));
			end
			default: program_regs(0, 0, 0, 65535, 0, $urandom_range(1530, 2047), 2047);
		endcase
	endtask

	// Random reading, mostly close to or between the active breakpoints.
	function automatic logic [VAL_W-1:0] pick_reading();
		int bp[3];
		int r;
		if (sb.regs.profile_select) begin
			bp[0] = VALUE_LOW_DEF; bp[1] = VALUE_MEDIUM_DEF; bp[2] = VALUE_HIGH_DEF;
		end else begin
			bp[0] = sb.regs.value_low; bp[1] = sb.regs.value_medium; bp[2] = sb.regs.value_high;
		end
		case ($urandom_range(0, 3))
			0: r = $urandom_range(0, 65535);
			1: r = bp[$urandom_range(0, 2)] + $urandom_range(0, 8) - 4;
			2: r = bp[$urandom_range(0, 2)] + $urandom_range(0, 600) - 300;
			default: r = $urandom_range(bp[0], bp[2]);
		endcase
		if (r < 0)
			r = 0;
		if (r > 65535)
			r = 65535;
		return VAL_W'(r);
	endfunction

	// Main sequence: reset, directed readings, then random phases.
	initial begin
		int p, i;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		req_if.valid = 1'b0;
		req_if.reading = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset profile: around and on each breakpoint, plus the field extremes.
		send_reading(16'd0);
		send_reading(16'd399);
		send_reading(16'd400);
		send_reading(16'd401);
		send_reading(16'd600);
		send_reading(16'd799);
		send_reading(16'd800);
		send_reading(16'd801);
		send_reading(16'd999);
		send_reading(16'd1000);
		send_reading(16'd1001);
		send_reading(16'd65535);
		drain(20);

		// Widest spans and hue registers above the wheel size.
		program_regs(0, 0, 32768, 65535, 2047, 0, 1529);
		send_reading(16'd0);
		send_reading(16'd1);
		send_reading(16'd16384);
		send_reading(16'd32767);
		send_reading(16'd32768);
		send_reading(16'd32769);
		send_reading(16'd65534);
		send_reading(16'd65535);
		drain(20);

		// Exact halves on rising and falling segments, and an out-of-range index.
		write_reg(REG_UNUSED, 16'hFFFF);
		program_regs(0, 0, 2, 4, 0, 1, 0);
		send_reading(16'd1);
		send_reading(16'd3);
		send_reading(16'd5);

		for (p = 0; p < 8; p++) begin
			drain(20);
			program_random(p % 5);
			case (p % 4)
				0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
				1: begin src_idle_pct = 61; snk_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  snk_stall_pct = 61; end
				default: begin src_idle_pct = 22; snk_stall_pct = 22; end
			endcase
			for (i = 0; i < 206; i++) begin
				// Long output hold-off so the pipeline fills and stalls its input.
				if (p == 0 && i == 60)
					hold_req = 250;
				// Sender pause until everything in flight has come back.
				if (p == 0 && i == 140)
					drain(0);
				send_reading(pick_reading());
			end
		end
		drain(20);

		if (sb.errors == 0 && sb.pending() == 0)
			$display("value_to_hue_gauge_color_core_test OK");
		else
			$display("value_to_hue_gauge_color_core_test NOT OK");
		$finish;
	end

endmodule

// ----- sim.f -----
src/hgc_pkg.sv
src/hgc_ifs.sv
src/hgc_seg.sv
src/hgc_div.sv
src/hgc_wheel.sv
src/value_to_hue_gauge_color_core.sv
test/value_to_hue_gauge_color_core_test.sv
